/* src/qms_pkg.sv */
// shared constants and the arctangent table for the quaternion misorientation statistics core
package qms_pkg;
	localparam int MaxRows = 65536;
	localparam int CntW = 25;
	localparam int CordicSteps = 16;
	localparam logic [17:0] HalfPiQ16 = 18'd102944;
	localparam logic [14:0] AngleMax = 15'd25736;

	localparam logic [1:0] RegW = 2'd0;
	localparam logic [1:0] RegX = 2'd1;
	localparam logic [1:0] RegY = 2'd2;
	localparam logic [1:0] RegZ = 2'd3;

	function automatic logic [16:0] atan_q16(input logic [3:0] i);
		logic [16:0] r;
		begin
			unique case (i)
				4'd0: r = 17'd51472;
				4'd1: r = 17'd30386;
				4'd2: r = 17'd16055;
				4'd3: r = 17'd8150;
				4'd4: r = 17'd4091;
				4'd5: r = 17'd2047;
				4'd6: r = 17'd1024;
				4'd7: r = 17'd512;
				4'd8: r = 17'd256;
				4'd9: r = 17'd128;
				4'd10: r = 17'd64;
				4'd11: r = 17'd32;
				4'd12: r = 17'd16;
				4'd13: r = 17'd8;
				4'd14: r = 17'd4;
				default: r = 17'd2;
			endcase
			return r;
		end
	endfunction
endpackage

/* src/qms_divider.sv */
// restoring divider, one quotient bit per cycle
module qms_divider import qms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [47:0] quo
);
	logic [47:0] n_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], n_q[47]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
				n_q <= num;
				den_q <= den;
				rem_q <= '0;
			end else if (busy_q) begin
				if (!trial[32]) begin
					rem_q <= trial;
					n_q <= {n_q[46:0], 1'b1};
				end else begin
					rem_q <= shifted;
					n_q <= {n_q[46:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	assign quo = n_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("divider done while busy");
endmodule

/* src/quaternion_misorientation_stats_core.sv */
// top level: quaternion geodesic angle and set statistics
// Each item is a sample quaternion in Q1.15. The core multiplies it with the
// reference quaternion (registers 0..3: w, x, y, z) one component per cycle on a
// single 17x17 multiplier. The same multiplier squares the clamped dot product in
// three partial products, squares s15 for the s^2 sum, and squares s in three
// more partial products for the radicand 1-s^2. A 31-step bit-pair square root
// and 16 CORDIC vectoring steps then give acos(s) in Q2.13. s and s^2 are summed
// over the set. On the item flagged last_sample the core divides by the count
// with a shared 48-step restoring divider, once for c_stat and once for d_stat,
// and then clears the sums. The core takes one item at a time: after the result of
// an ordinary item is loaded into the output register, it can take the next item
// in the following cycle. A last item also passes through the two divider runs
// before its result is loaded. in_stall is high while an item is in work. A
// result waits in the output register while out_stall is high; the next item is
// taken meanwhile and only waits before its own result if the previous one has
// still not left. Configuration writes are always taken.
module quaternion_misorientation_stats_core import qms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] q_w,
	input  logic [15:0] q_x,
	input  logic [15:0] q_y,
	input  logic [15:0] q_z,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] angle,
	output logic [15:0] c_stat,
	output logic [15:0] d_stat,
	output logic        is_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DOT, ST_SQ, ST_FIN, ST_ACC, ST_RSQ, ST_RAD, ST_SQRT, ST_ROT,
		ST_CORDIC, ST_ANG, ST_CDIV, ST_DDIV, ST_OUT
	} state_t;

	state_t state_q;
	logic signed [15:0] ref_q [4];
	logic signed [15:0] smp_q [4];
	logic        last_q;
	logic [1:0]  k_q;
	logic signed [33:0] dot_q;
	logic signed [31:0] s30_q;
	logic [47:0] sum_sq_q;
	logic signed [47:0] sum_lin_q;
	logic [CntW-1:0] cnt_q;
	// square root
	logic [61:0] rad_q;
	logic [4:0]  it_q;
	// cordic
	logic signed [33:0] cx_q, cy_q;
	logic signed [18:0] cz_q;
	// statistics waiting for the output register
	logic [15:0] cstat_q;
	logic [15:0] dstat_q;
	logic div_start;
	logic div_done;
	logic [47:0] div_num;
	logic [31:0] div_den;
	logic [47:0] div_quo;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	// |dot| clamped to 2^30, as 31 bits
	logic [30:0] mag;
	logic [33:0] dabs;
	assign dabs = dot_q[33] ? 34'(-dot_q) : 34'(dot_q);
	assign mag = (dabs > 34'd1073741824) ? 31'd1073741824 : dabs[30:0];

	// |s| in Q2.30, at most 2^30
	logic [30:0] s30_mag;
	assign s30_mag = s30_q[31] ? 31'(-s30_q) : s30_q[30:0];

	// 31-bit square in three passes: value = hi*2^15 + lo
	logic [30:0] sq_mag;
	logic [15:0] mhi;
	logic [14:0] mlo;
	logic [1:0]  sq_ph_q;
	logic [61:0] sq_acc_q;
	assign sq_mag = (state_q == ST_RSQ) ? s30_mag : mag;
	assign mhi = sq_mag[30:15];
	assign mlo = sq_mag[14:0];

	// s15 and its square
	logic signed [16:0] s15;
	assign s15 = s30_q[31:15];

	// shared multiplier
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] mul_p;
	logic [31:0] pp;
	logic [33:0] s15sq;
	always_comb begin
		mul_a = {smp_q[k_q][15], smp_q[k_q]};
		mul_b = {ref_q[k_q][15], ref_q[k_q]};
		if (state_q == ST_ACC) begin
			mul_a = s15;
			mul_b = s15;
		end else if (state_q == ST_SQ || state_q == ST_RSQ) begin
			unique case (sq_ph_q)
				2'd0: begin
					mul_a = {1'b0, mhi};
					mul_b = {1'b0, mhi};
				end
				2'd1: begin
					mul_a = {1'b0, mhi};
					mul_b = {2'b00, mlo};
				end
				default: begin
					mul_a = {2'b00, mlo};
					mul_b = {2'b00, mlo};
				end
			endcase
		end
	end
	assign mul_p = mul_a * mul_b;
	assign pp = mul_p[31:0];
	assign s15sq = mul_p;

	// digit recurrence over the 62-bit radicand, two bits a step
	logic [31:0] sr_q;
	logic [33:0] srem_q;
	logic [33:0] strial;
	logic [33:0] srem_sh;
	assign srem_sh = {srem_q[31:0], rad_q[61:60]};
	assign strial = srem_sh - {sr_q, 2'b01};

	// cordic step
	logic signed [33:0] sx, sy;
	assign sx = cx_q >>> it_q[3:0];
	assign sy = cy_q >>> it_q[3:0];

	// angle rounding and clamp
	logic [18:0] zr;
	logic [14:0] angle_next;
	assign zr = cz_q[18] ? 19'd0 : 19'((cz_q + 19'sd4) >>> 3);
	assign angle_next = (zr > 19'(AngleMax)) ? AngleMax : zr[14:0];

	logic [CntW-1:0] n_eff;
	logic [26:0] n3;
	assign n_eff = (cnt_q == '0) ? CntW'(1) : cnt_q;
	assign n3 = 27'(n_eff) + (27'(n_eff) << 1);

	// d statistic saturated at the top
	logic [15:0] dstat_next;
	assign dstat_next = (div_quo > 48'd65535) ? 16'h7FFF : {~div_quo[15], div_quo[14:0]};

	qms_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	always_comb begin
		// c: (n*2^23 - sum_sq + 96n) / 192n
		div_num = (48'(n_eff) << 23) - sum_sq_q + (48'(n_eff) << 6) + (48'(n_eff) << 5);
		div_den = (32'(n_eff) << 7) + (32'(n_eff) << 6);
		if (state_q == ST_CDIV) begin
			// d: (n*2^17 + 2*sum_lin + floor(3n/2)) / 3n
			div_num = (48'(n_eff) << 17) + 48'(sum_lin_q <<< 1) + 48'(n3 >> 1);
			div_den = 32'(n3);
		end
		div_start = (state_q == ST_ANG && last_q) || (state_q == ST_CDIV && div_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ref_q[0] <= 16'sd32767;
			ref_q[1] <= '0;
			ref_q[2] <= '0;
			ref_q[3] <= '0;
			sum_sq_q <= '0;
			sum_lin_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
			angle <= '0;
			c_stat <= '0;
			d_stat <= '0;
			is_last <= 1'b0;
			k_q <= '0;
			it_q <= '0;
			sq_ph_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					RegW: ref_q[0] <= cfg_data;
					RegX: ref_q[1] <= cfg_data;
					RegY: ref_q[2] <= cfg_data;
					RegZ: ref_q[3] <= cfg_data;
				endcase
			end
			// result register: loaded when free, cleared when taken
			if (state_q == ST_OUT && out_free) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						smp_q[0] <= q_w;
						smp_q[1] <= q_x;
						smp_q[2] <= q_y;
						smp_q[3] <= q_z;
						last_q <= last_sample;
						dot_q <= '0;
						k_q <= '0;
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					dot_q <= dot_q + mul_p;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						sq_ph_q <= '0;
						sq_acc_q <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ, ST_RSQ: begin
					sq_ph_q <= sq_ph_q + 2'd1;
					unique case (sq_ph_q)
						2'd0: sq_acc_q <= sq_acc_q + (62'(pp) << 30);
						2'd1: sq_acc_q <= sq_acc_q + (62'(pp) << 16);
						default: sq_acc_q <= sq_acc_q + 62'(pp);
					endcase
					if (sq_ph_q == 2'd2) state_q <= (state_q == ST_SQ) ? ST_FIN : ST_RAD;
				end
				ST_FIN: begin
					// s = 2cp^2 - 1 in Q2.30
					s30_q <= 32'(sq_acc_q >> 29) - 32'sd1073741824;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// full count: the item still gets its angle
					if (cnt_q < CntW'(MaxRows)) begin
						sum_lin_q <= sum_lin_q + 48'(s15);
						sum_sq_q <= sum_sq_q + 48'(s15sq >> 7);
						cnt_q <= cnt_q + CntW'(1);
					end
					sq_ph_q <= '0;
					sq_acc_q <= '0;
					state_q <= ST_RSQ;
				end
				ST_RAD: begin
					// radicand 2^60 - s^2
					rad_q <= (62'd1 << 60) - sq_acc_q;
					sr_q <= '0;
					srem_q <= '0;
					it_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					rad_q <= {rad_q[59:0], 2'b00};
					if (!strial[33]) begin
						srem_q <= strial;
						sr_q <= {sr_q[30:0], 1'b1};
					end else begin
						srem_q <= srem_sh;
						sr_q <= {sr_q[30:0], 1'b0};
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'd30) state_q <= ST_ROT;
				end
				ST_ROT: begin
					// negative s: start a quarter turn on
					if (s30_q[31]) begin
						cx_q <= {2'b00, sr_q};
						cy_q <= -34'(s30_q);
						cz_q <= 19'(HalfPiQ16);
					end else begin
						cx_q <= 34'(s30_q);
						cy_q <= {2'b00, sr_q};
						cz_q <= '0;
					end
					it_q <= '0;
					state_q <= ST_CORDIC;
				end
				ST_CORDIC: begin
					if (!cy_q[33]) begin
						cx_q <= cx_q + sy;
						cy_q <= cy_q - sx;
						cz_q <= cz_q + 19'(atan_q16(it_q[3:0]));
					end else begin
						cx_q <= cx_q - sy;
						cy_q <= cy_q + sx;
						cz_q <= cz_q - 19'(atan_q16(it_q[3:0]));
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'(CordicSteps - 1)) state_q <= ST_ANG;
				end
				ST_ANG: begin
					// last item starts the c division here
					state_q <= last_q ? ST_CDIV : ST_OUT;
				end
				ST_CDIV: begin
					if (div_done) begin
						cstat_q <= div_quo[15:0];
						state_q <= ST_DDIV;
					end
				end
				ST_DDIV: begin
					if (div_done) begin
						dstat_q <= dstat_next;
						sum_sq_q <= '0;
						sum_lin_q <= '0;
						cnt_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						angle <= angle_next;
						is_last <= last_q;
						c_stat <= last_q ? cstat_q : 16'd0;
						d_stat <= last_q ? dstat_q : 16'd0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxRows)) else $error("count past limit");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({angle, c_stat, d_stat, is_last}))
		else $error("stalled result changed");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_CDIV || state_q == ST_DDIV))
		else $error("divider finished with nobody waiting");
endmodule
